// File: sv/shr_pkg.sv
// Package: constants, codes and shared types of the snapshot history ring.
`default_nettype none

package shr_pkg;

    localparam int SLOTS    = 8;
    localparam int MAX_ROWS = 64;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W  = SLOT_W + ROW_W;
    localparam int DEPTH   = SLOTS * MAX_ROWS;
    localparam int WORD_W  = 32;
    localparam int AGE_W   = 8;
    localparam int CNT_W   = 4;
    localparam int TOTAL_W = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_ISSUE,
        S_DATA
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  word_value;
        logic [ROW_W-1:0]   row_index;
        logic [ROWS_W-1:0]  row_count;
        logic               last_word;
        logic [CNT_W-1:0]   stored_snapshots;
        logic [TOTAL_W-1:0] captured_total;
    } t_result;

endpackage

`default_nettype wire

// File: sv/shr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module shr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/shr_ctrl.sv
// Sequencer: ring pointers, counters, command decode and word-by-word readout.
`default_nettype none

module shr_ctrl
    import shr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_op               i_opcode,
    input  wire logic [WORD_W-1:0] i_element,
    input  wire logic [AGE_W-1:0]  i_age,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [ROWS_W-1:0] i_cfg_data,
    input  wire logic              i_out_free,
    output logic                   o_res_valid,
    output t_result                o_res,
    output t_ram_req               o_ram,
    input  wire logic [WORD_W-1:0] i_rdata
);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]    r_filled, n_filled;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [ROW_W-1:0]    r_pos, n_pos;
    logic [ROWS_W-1:0]   r_rows, n_rows;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                r_err, n_err;

    logic                w_in_acc;
    logic                w_cfg_acc;
    logic                w_commit;
    logic                w_last;
    logic [SLOT_W:0]     w_slot_sum;
    logic [SLOT_W:0]     w_slot_fix;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    assign w_commit = (({1'b0, r_pos} + ROWS_W'(1)) >= r_rows);
    assign w_last   = (({1'b0, r_row} + ROWS_W'(1)) == r_rows);

    // age is below the stored count here, so the sum stays under twice SLOTS
    assign w_slot_sum = ({1'b0, r_head} + (SLOT_W+1)'(SLOTS - 1)) - i_age[SLOT_W:0];
    assign w_slot_fix = (w_slot_sum >= (SLOT_W+1)'(SLOTS))
                        ? (w_slot_sum - (SLOT_W+1)'(SLOTS)) : w_slot_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_filled <= '0;
            r_total  <= '0;
            r_pos    <= '0;
            r_rows   <= ROWS_W'(1);
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_filled <= n_filled;
            r_total  <= n_total;
            r_pos    <= n_pos;
            r_rows   <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_row  <= n_row;
        r_err  <= n_err;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_filled = r_filled;
        n_total  = r_total;
        n_pos    = r_pos;
        n_rows   = r_rows;
        n_slot   = r_slot;
        n_row    = r_row;
        n_err    = r_err;

        o_ram       = '0;
        o_ram.waddr = {r_head, r_pos};
        o_ram.wdata = i_element;
        o_ram.raddr = {r_slot, r_row};

        o_res_valid            = 1'b0;
        o_res.status           = r_err;
        o_res.word_value       = '0;
        o_res.row_index        = '0;
        o_res.row_count        = r_rows;
        o_res.last_word        = 1'b1;
        o_res.stored_snapshots = r_filled;
        o_res.captured_total   = r_total;

        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    if (i_cfg_data == '0) begin
                        n_rows = ROWS_W'(1);
                    end else if (i_cfg_data > ROWS_W'(MAX_ROWS)) begin
                        n_rows = ROWS_W'(MAX_ROWS);
                    end else begin
                        n_rows = i_cfg_data;
                    end
                    n_head   = '0;
                    n_filled = '0;
                    n_pos    = '0;
                end else if (w_in_acc) begin
                    case (i_opcode)
                        OP_PUSH: begin
                            o_ram.we = 1'b1;
                            if (w_commit) begin
                                n_pos  = '0;
                                n_head = (r_head == SLOT_W'(SLOTS - 1))
                                         ? '0 : r_head + SLOT_W'(1);
                                if (r_filled < CNT_W'(SLOTS)) begin
                                    n_filled = r_filled + CNT_W'(1);
                                end
                                if (r_total != '1) begin
                                    n_total = r_total + TOTAL_W'(1);
                                end
                            end else begin
                                n_pos = r_pos + ROW_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_head   = '0;
                            n_filled = '0;
                            n_pos    = '0;
                        end
                        OP_QUERY: begin
                            n_err   = 1'b0;
                            n_state = S_RESP;
                        end
                        OP_GET: begin
                            if (i_age >= AGE_W'(r_filled)) begin
                                n_err   = 1'b1;
                                n_state = S_RESP;
                            end else begin
                                n_err   = 1'b0;
                                n_slot  = w_slot_fix[SLOT_W-1:0];
                                n_row   = '0;
                                n_state = S_ISSUE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ISSUE: begin
                if (i_out_free) begin
                    o_ram.re = 1'b1;
                    n_state  = S_DATA;
                end
            end
            S_DATA: begin
                // output register was freed when the read was issued
                o_res_valid      = 1'b1;
                o_res.word_value = i_rdata;
                o_res.row_index  = r_row;
                o_res.last_word  = w_last;
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/snapshot_history_ring_top.sv
// Top level of the snapshot history ring: ports, store, sequencer, output register.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser opcode, tdata word + age
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser status, tlast, tdata rest
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_data rows_in_use
//
// Push and clear finish in the cycle they are accepted; back-to-back pushes run at one per cycle.
// Query and a get of an age not held are decoded, then wait in a response state until
// the output register is free and load it.
// A get is decoded, then for each word the store is read once the output register is free,
// and the word is then loaded into the output register.
// Reset leaves an empty ring with one word per snapshot; the store is not cleared.
// A stalled output holds the sequencer; input is not taken until the command is done.
`default_nettype none

module snapshot_history_ring_top
    import shr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] element_value, [39:32] snapshot_age
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] word_value, [37:32] row_index, [44:38] row_count,
    // [48:45] stored_snapshots, [80:49] captured_total, [87:81] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] status
    output logic [0:0]                  m_axis_tuser,
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [ROWS_W-1:0]      i_cfg_data
);

    t_ram_req           w_ram;
    t_result            w_res;
    logic               w_res_valid;
    logic               w_out_free;
    logic [WORD_W-1:0]  w_rdata;

    logic               r_out_valid;
    t_result            r_out;

    assign w_out_free = !r_out_valid || m_axis_tready;

    shr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (t_op'(s_axis_tuser)),
        .i_element   (s_axis_tdata[WORD_W-1:0]),
        .i_age       (s_axis_tdata[WORD_W +: AGE_W]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata)
    );

    shr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out.status;
    assign m_axis_tlast    = r_out.last_word;
    assign m_axis_tdata    = {7'd0, r_out.captured_total, r_out.stored_snapshots,
                              r_out.row_count, r_out.row_index, r_out.word_value};

endmodule

`default_nettype wire

// File: verif/snapshot_history_ring_tb.sv
// Self-checking testbench for snapshot_history_ring_top: directed table, then random traffic.

module testbench;
    import shr_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_N        = 25;

    typedef struct packed {
        t_op          op;
        logic [31:0]  value;
        logic [7:0]   age;
        logic         known;
        logic         k_status;
        logic [3:0]   k_stored;
        logic [31:0]  k_total;
    } t_dir_row;

    // known rows carry their single result; the others go through the ring predictor
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{OP_QUERY, 32'h0000_0000, 8'd0,   1'b1, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd0,   1'b1, 1'b1, 4'd0, 32'd0},
        '{OP_GET,   32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 4'd0, 32'd0},
        '{OP_PUSH,  32'h8000_0000, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h7FFF_FFFF, 8'd255, 1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'hFFFF_FFFF, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h0000_0000, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd3,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd4,   1'b1, 1'b1, 4'd4, 32'd4},
        '{OP_QUERY, 32'h0000_0000, 8'd0,   1'b1, 1'b0, 4'd4, 32'd4},
        '{OP_CLEAR, 32'h0000_0000, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_QUERY, 32'h0000_0000, 8'd0,   1'b1, 1'b0, 4'd0, 32'd4},
        '{OP_GET,   32'h0000_0000, 8'd0,   1'b1, 1'b1, 4'd0, 32'd4},
        '{OP_PUSH,  32'h5555_5555, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'hAAAA_AAAA, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h0000_0001, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h8000_0001, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h1234_5678, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'hFEDC_BA98, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h7FFF_FFFE, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_PUSH,  32'h0F0F_0F0F, 8'd0,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd7,   1'b0, 1'b0, 4'd0, 32'd0},
        '{OP_GET,   32'h0000_0000, 8'd8,   1'b1, 1'b1, 4'd8, 32'd12},
        '{OP_QUERY, 32'h0000_0000, 8'd0,   1'b1, 1'b0, 4'd8, 32'd12}
    };

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]              s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [ROWS_W-1:0]       i_cfg_data    = '0;

    logic idle_on     = 1'b1;
    logic hold_go     = 1'b0;
    logic hold_active = 1'b0;
    int   stall_left  = 0;
    int   fail_count  = 0;
    int   in_count    = 0;
    int   out_count   = 0;

    // ring predictor state
    logic [WORD_W-1:0] ring_mem [DEPTH];
    int unsigned       pred_head  = 0;
    int unsigned       ring_fill  = 0;
    int unsigned       word_pos   = 0;
    logic [31:0]       commit_cnt = '0;
    logic [ROWS_W-1:0] rows_setting = 7'd1;
    t_result           due_results [$];

    snapshot_history_ring_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned active_rows();
        if (rows_setting == 0) return 1;
        if (rows_setting > MAX_ROWS) return MAX_ROWS;
        return 32'(rows_setting);
    endfunction

    function automatic t_result make_result(logic st, logic [31:0] w, int unsigned row,
                                            logic last);
        t_result r;
        r.status           = st;
        r.word_value       = w;
        r.row_index        = ROW_W'(row);
        r.row_count        = ROWS_W'(active_rows());
        r.last_word        = last;
        r.stored_snapshots = CNT_W'(ring_fill);
        r.captured_total   = commit_cnt;
        return r;
    endfunction

    function automatic void predict_ring_op(t_op op, logic [31:0] value, logic [7:0] age);
        int unsigned rows;
        int unsigned slot;
        rows = active_rows();
        case (op)
            OP_PUSH: begin
                ring_mem[ADDR_W'(pred_head * MAX_ROWS + word_pos)] = value;
                word_pos++;
                if (word_pos >= rows) begin
                    word_pos  = 0;
                    pred_head = (pred_head + 1) % SLOTS;
                    if (ring_fill < SLOTS) ring_fill++;
                    if (commit_cnt != '1) commit_cnt++;
                end
            end
            OP_CLEAR: begin
                pred_head = 0;
                ring_fill = 0;
                word_pos  = 0;
            end
            OP_QUERY: due_results.push_back(make_result(1'b0, '0, 0, 1'b1));
            OP_GET: begin
                if (age >= ring_fill) begin
                    due_results.push_back(make_result(1'b1, '0, 0, 1'b1));
                end else begin
                    slot = (pred_head + SLOTS - 1 - age) % SLOTS;
                    for (int unsigned r = 0; r < rows; r++)
                        due_results.push_back(
                            make_result(1'b0, ring_mem[ADDR_W'(slot * MAX_ROWS + r)],
                                        r, r + 1 == rows));
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        out_count++;
        if (due_results.size() == 0) begin
            $error("unexpected result transfer, word 0x%0h", m_axis_tdata[31:0]);
            fail_count++;
            return;
        end
        want = due_results.pop_front();
        compare_field("status", 32'(want.status), 32'(m_axis_tuser[0]));
        compare_field("word_value", want.word_value, m_axis_tdata[31:0]);
        compare_field("row_index", 32'(want.row_index), 32'(m_axis_tdata[37:32]));
        compare_field("row_count", 32'(want.row_count), 32'(m_axis_tdata[44:38]));
        compare_field("last_word", 32'(want.last_word), 32'(m_axis_tlast));
        compare_field("stored_snapshots", 32'(want.stored_snapshots),
                      32'(m_axis_tdata[48:45]));
        compare_field("captured_total", want.captured_total, m_axis_tdata[80:49]);
    endfunction

    // result side: checks every transfer, random stall bursts, long hold when asked
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
        if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    task automatic send_item(input t_op op, input logic [31:0] value, input logic [7:0] age);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {age, value};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        in_count++;
    endtask

    task automatic issue(input t_op op, input logic [31:0] value, input logic [7:0] age);
        send_item(op, value, age);
        predict_ring_op(op, value, age);
    endtask

    task automatic set_rows(input logic [ROWS_W-1:0] rows);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        rows_setting = rows;
        pred_head    = 0;
        ring_fill    = 0;
        word_pos     = 0;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly whole snapshots and valid ages, some partials, queries, clears and noise
    task automatic run_random(input int n);
        int          sent;
        int          pick;
        int          cnt;
        int          sel;
        logic [7:0]  age;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (pick < 45) cnt = active_rows() - word_pos;
                else cnt = $urandom_range(1, active_rows());
                repeat (cnt) issue(OP_PUSH, $urandom, 8'($urandom));
                sent += cnt;
            end else begin
                if (pick < 80) begin
                    sel = $urandom_range(0, 7);
                    if (ring_fill == 0 || sel == 0) age = 8'($urandom_range(ring_fill, 255));
                    else if (sel < 3) age = 8'(ring_fill - 1);
                    else age = 8'($urandom_range(0, ring_fill - 1));
                    issue(OP_GET, $urandom, age);
                end else if (pick < 92) begin
                    issue(OP_QUERY, $urandom, 8'($urandom));
                end else if (pick < 96) begin
                    issue(OP_CLEAR, $urandom, 8'($urandom));
                end else begin
                    issue(t_op'($urandom_range(0, 3)), $urandom, 8'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial begin
        t_result known_res;
        int      k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_N; k++) begin
            send_item(DIR_TAB[k].op, DIR_TAB[k].value, DIR_TAB[k].age);
            if (DIR_TAB[k].known) begin
                // row_count 1 is the setting after reset
                known_res = '{DIR_TAB[k].k_status, 32'd0, 6'd0, 7'd1, 1'b1,
                              DIR_TAB[k].k_stored, DIR_TAB[k].k_total};
                due_results.push_back(known_res);
            end else begin
                predict_ring_op(DIR_TAB[k].op, DIR_TAB[k].value, DIR_TAB[k].age);
            end
        end
        drain();

        set_rows(7'd0);
        run_random(15);
        drain();

        // widest snapshot, then a long output stall while gets keep coming
        set_rows(7'd127);
        repeat (MAX_ROWS) issue(OP_PUSH, $urandom, 8'($urandom));
        hold_go <= 1'b1;
        issue(OP_GET, $urandom, 8'd0);
        issue(OP_QUERY, $urandom, 8'($urandom));
        issue(OP_GET, $urandom, 8'd0);
        issue(OP_GET, $urandom, 8'd1);
        repeat (3) issue(OP_PUSH, $urandom, 8'($urandom));
        drain();

        set_rows(7'd64);
        repeat (6) issue(OP_PUSH, $urandom, 8'($urandom));
        issue(OP_QUERY, $urandom, 8'($urandom));
        issue(OP_GET, $urandom, 8'd0);
        issue(OP_CLEAR, $urandom, 8'($urandom));
        issue(OP_QUERY, $urandom, 8'($urandom));
        drain();

        set_rows(7'($urandom_range(3, 5)));
        run_random(25);
        drain();

        idle_on <= 1'b0;
        set_rows(7'd2);
        run_random(20);
        drain();

        $display("Sent %0d input transfers, checked %0d result transfers", in_count, out_count);
        $display("Row settings 0, 127, 64 and small ones; wrap, overwrite, errors, long stall");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
sv/shr_pkg.sv
sv/shr_ram.sv
sv/shr_ctrl.sv
sv/snapshot_history_ring_top.sv
verif/snapshot_history_ring_tb.sv
